// ===== hdl/nttfwd_pkg.sv =====
// shared constants, codes and state types for the forward ntt block
// no dependencies
`timescale 1ns / 1ps

package nttfwd_pkg;

   localparam int MAX_POINTS_DEF = 4096;
   localparam int WORD_BITS_DEF  = 62;
   localparam int INDEX_BITS     = 12;
   localparam int KIND_BITS      = 2;
   localparam int SIZE_BITS      = 4;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODULUS   = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIZE_LOG2 = 1'b1;

   localparam logic [SIZE_BITS-1:0] SIZE_LOG2_RESET = 4'd12;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_WR_TWIDDLE = 2'd0,
      KIND_WR_COEF    = 2'd1,
      KIND_RUN        = 2'd2,
      KIND_RD_COEF    = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_LD_X,
      ST_LD_Y,
      ST_START,
      ST_BUSY,
      ST_WR_Y
   } ctl_state_type;

   typedef enum logic [2:0] {
      BF_IDLE,
      BF_RED_X,
      BF_RED_Y,
      BF_RED_W,
      BF_MUL_DBL,
      BF_MUL_ADD,
      BF_FIN
   } bf_phase_type;

endpackage

// ===== hdl/nttfwd_ram.sv =====
// generic simple dual port ram, one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps

module nttfwd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/nttfwd_bfly.sv =====
// iterative modular butterfly: reduces x, y, w mod q bit-serially, then
// shift-add multiply w*y mod q, then x+wy and x-wy mod q
// depends on nttfwd_pkg
`timescale 1ns / 1ps

module nttfwd_bfly #(
   parameter int WORD_BITS = nttfwd_pkg::WORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WORD_BITS-1:0] q,
   input  logic [WORD_BITS-1:0] x,
   input  logic [WORD_BITS-1:0] y,
   input  logic [WORD_BITS-1:0] w,
   output logic                 done,
   output logic [WORD_BITS-1:0] sum,
   output logic [WORD_BITS-1:0] diff
);

   localparam int KW = $clog2(WORD_BITS);
   localparam logic [KW-1:0] K_TOP = KW'(WORD_BITS - 1);

   nttfwd_pkg::bf_phase_type phase_ff, phase_in;
   logic [KW-1:0]        k_ff, k_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic [WORD_BITS-1:0] x_ff, x_in, y_ff, y_in, w_ff, w_in;
   logic [WORD_BITS-1:0] sum_ff, sum_in, diff_ff, diff_in;
   logic                 done_ff, done_in;

   logic                 step_bit;
   logic [WORD_BITS:0]   mod_t;
   logic [WORD_BITS:0]   mod_r;
   logic [WORD_BITS-1:0] mod_out;
   logic [WORD_BITS:0]   sum_t;
   logic                 last;

   always_comb begin
      case (phase_ff)
         nttfwd_pkg::BF_RED_X: step_bit = x_ff[k_ff];
         nttfwd_pkg::BF_RED_Y: step_bit = y_ff[k_ff];
         nttfwd_pkg::BF_RED_W: step_bit = w_ff[k_ff];
         default:              step_bit = 1'b0;
      endcase
      if (phase_ff == nttfwd_pkg::BF_MUL_ADD) begin
         mod_t = {1'b0, acc_ff} + {1'b0, y_ff};
      end else begin
         mod_t = {acc_ff, step_bit};
      end
      mod_r   = (mod_t >= {1'b0, q}) ? (mod_t - {1'b0, q}) : mod_t;
      mod_out = mod_r[WORD_BITS-1:0];
      sum_t   = {1'b0, x_ff} + {1'b0, acc_ff};
      last    = (k_ff == '0);
   end

   always_comb begin
      phase_in = phase_ff;
      k_in     = k_ff;
      acc_in   = acc_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      w_in     = w_ff;
      sum_in   = sum_ff;
      diff_in  = diff_ff;
      done_in  = 1'b0;
      case (phase_ff)
         nttfwd_pkg::BF_IDLE: begin
            if (start) begin
               x_in     = x;
               y_in     = y;
               w_in     = w;
               acc_in   = '0;
               k_in     = K_TOP;
               phase_in = nttfwd_pkg::BF_RED_X;
            end
         end
         nttfwd_pkg::BF_RED_X, nttfwd_pkg::BF_RED_Y, nttfwd_pkg::BF_RED_W: begin
            acc_in = mod_out;
            if (last) begin
               acc_in = '0;
               k_in   = K_TOP;
               case (phase_ff)
                  nttfwd_pkg::BF_RED_X: begin
                     x_in     = mod_out;
                     phase_in = nttfwd_pkg::BF_RED_Y;
                  end
                  nttfwd_pkg::BF_RED_Y: begin
                     y_in     = mod_out;
                     phase_in = nttfwd_pkg::BF_RED_W;
                  end
                  default: begin
                     w_in     = mod_out;
                     phase_in = nttfwd_pkg::BF_MUL_DBL;
                  end
               endcase
            end else begin
               k_in = k_ff - 1'b1;
            end
         end
         nttfwd_pkg::BF_MUL_DBL: begin
            acc_in = mod_out;
            if (w_ff[k_ff]) begin
               phase_in = nttfwd_pkg::BF_MUL_ADD;
            end else if (last) begin
               phase_in = nttfwd_pkg::BF_FIN;
            end else begin
               k_in = k_ff - 1'b1;
            end
         end
         nttfwd_pkg::BF_MUL_ADD: begin
            acc_in = mod_out;
            if (last) begin
               phase_in = nttfwd_pkg::BF_FIN;
            end else begin
               k_in     = k_ff - 1'b1;
               phase_in = nttfwd_pkg::BF_MUL_DBL;
            end
         end
         nttfwd_pkg::BF_FIN: begin
            sum_in   = (sum_t >= {1'b0, q}) ? WORD_BITS'(sum_t - {1'b0, q})
                                            : sum_t[WORD_BITS-1:0];
            diff_in  = (x_ff >= acc_ff) ? (x_ff - acc_ff) : (x_ff - acc_ff + q);
            done_in  = 1'b1;
            phase_in = nttfwd_pkg::BF_IDLE;
         end
         default: phase_in = nttfwd_pkg::BF_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= nttfwd_pkg::BF_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      k_ff    <= k_in;
      acc_ff  <= acc_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      w_ff    <= w_in;
      sum_ff  <= sum_in;
      diff_ff <= diff_in;
   end

   assign done = done_ff;
   assign sum  = sum_ff;
   assign diff = diff_ff;

endmodule

// ===== hdl/ntt_forward_radix2_bitrev.sv =====
// forward ntt, radix-2 cooley-tukey, bit-reversed output, coefficient and twiddle rams
// writes go straight into the rams; a read waits in its read state until the response slot is
// free, then registers its response. one write per cycle while idle (not during a run or a read);
// a run takes (len/2)*log2(len) butterflies, each done in turn on the bit-serial modular unit
// synchronous active-high reset clears control state and the error flag; rams are not cleared
`timescale 1ns / 1ps

module ntt_forward_radix2_bitrev #(
   parameter int MAX_POINTS = nttfwd_pkg::MAX_POINTS_DEF,
   parameter int WORD_BITS  = nttfwd_pkg::WORD_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   // request: tdata = index[11:0], value; tuser = kind
   input  logic                                                     req_tvalid,
   output logic                                                     req_tready,
   input  logic [((nttfwd_pkg::INDEX_BITS+WORD_BITS+7)/8)*8-1:0]     req_tdata,
   input  logic [nttfwd_pkg::KIND_BITS-1:0]                          req_tuser,
   // response: tdata = index_out[11:0], coefficient; tuser = range_error
   output logic                                                     rsp_tvalid,
   input  logic                                                     rsp_tready,
   output logic [((nttfwd_pkg::INDEX_BITS+WORD_BITS+7)/8)*8-1:0]     rsp_tdata,
   output logic                                                     rsp_tuser,
   input  logic                                                     csr_we,
   input  logic [nttfwd_pkg::CSR_INDEX_BITS-1:0]                     csr_index,
   input  logic [WORD_BITS-1:0]                                     csr_wdata
);

   localparam int DATA_W = ((nttfwd_pkg::INDEX_BITS + WORD_BITS + 7) / 8) * 8;
   localparam int AW     = $clog2(MAX_POINTS);
   localparam int CW     = AW + 1;
   localparam int IW     = nttfwd_pkg::INDEX_BITS;

   logic [IW-1:0]        req_index;
   logic [WORD_BITS-1:0] req_value;
   logic                 req_fire;
   logic                 val_ok;
   logic                 idx_ok;

   logic [WORD_BITS-1:0]            modulus_ff;
   logic [nttfwd_pkg::SIZE_BITS-1:0] size_log2_ff;
   logic                            error_ff, error_in;

   nttfwd_pkg::ctl_state_type state_ff, state_in;
   logic [CW-1:0] len_ff, len_in, m_ff, m_in, t_ff, t_in;
   logic [CW-1:0] i_ff, i_in, k_ff, k_in, base_ff, base_in;
   logic [CW-1:0] j_cur, len_run;
   logic [nttfwd_pkg::SIZE_BITS-1:0] l_run;
   logic [WORD_BITS-1:0] x_ff, x_in, w_ff, w_in;
   logic [IW-1:0]        rd_index_ff, rd_index_in;
   logic                 rd_ok_ff, rd_ok_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0]        rsp_index_ff, rsp_index_in;
   logic [WORD_BITS-1:0] rsp_coef_ff, rsp_coef_in;
   logic                 rsp_err_ff, rsp_err_in;

   logic                 coef_we, tw_we;
   logic [AW-1:0]        coef_waddr, coef_raddr, tw_raddr;
   logic [WORD_BITS-1:0] coef_wdata, coef_rdata, tw_rdata;

   logic                 bf_start, bf_done;
   logic [WORD_BITS-1:0] bf_sum, bf_diff;

   assign req_index = req_tdata[IW-1:0];
   assign req_value = req_tdata[IW +: WORD_BITS];
   assign req_fire  = req_tvalid && req_tready;
   assign val_ok    = (req_value < modulus_ff);
   assign idx_ok    = (32'(req_index) < 32'(MAX_POINTS));
   assign j_cur     = base_ff + k_ff;

   always_comb begin
      if (size_log2_ff < 4'd1) begin
         l_run = 4'd1;
      end else if (32'(size_log2_ff) > 32'(AW)) begin
         l_run = nttfwd_pkg::SIZE_BITS'(AW);
      end else begin
         l_run = size_log2_ff;
      end
      len_run = CW'(1) << l_run;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= WORD_BITS'(2);
         size_log2_ff <= nttfwd_pkg::SIZE_LOG2_RESET;
      end else if (csr_we) begin
         case (csr_index)
            nttfwd_pkg::CSR_MODULUS:   modulus_ff   <= csr_wdata;
            nttfwd_pkg::CSR_SIZE_LOG2: size_log2_ff <= csr_wdata[nttfwd_pkg::SIZE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      error_in     = error_ff;
      len_in       = len_ff;
      m_in         = m_ff;
      t_in         = t_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      base_in      = base_ff;
      x_in         = x_ff;
      w_in         = w_ff;
      rd_index_in  = rd_index_ff;
      rd_ok_in     = rd_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_index_in = rsp_index_ff;
      rsp_coef_in  = rsp_coef_ff;
      rsp_err_in   = rsp_err_ff;
      req_tready   = (state_ff == nttfwd_pkg::ST_IDLE);
      coef_we      = 1'b0;
      tw_we        = 1'b0;
      coef_waddr   = AW'(req_index);
      coef_wdata   = req_value;
      coef_raddr   = AW'(j_cur);
      tw_raddr     = AW'(m_ff + i_ff);
      bf_start     = 1'b0;
      case (state_ff)
         nttfwd_pkg::ST_IDLE: begin
            coef_raddr = AW'(req_index);
            if (req_fire) begin
               case (req_tuser)
                  nttfwd_pkg::KIND_WR_TWIDDLE, nttfwd_pkg::KIND_WR_COEF: begin
                     if (!val_ok) begin
                        error_in = 1'b1;
                     end else if (idx_ok) begin
                        tw_we   = (req_tuser == nttfwd_pkg::KIND_WR_TWIDDLE);
                        coef_we = (req_tuser == nttfwd_pkg::KIND_WR_COEF);
                     end
                  end
                  nttfwd_pkg::KIND_RUN: begin
                     if (modulus_ff >= WORD_BITS'(2)) begin
                        len_in   = len_run;
                        m_in     = CW'(1);
                        t_in     = len_run >> 1;
                        i_in     = '0;
                        k_in     = '0;
                        base_in  = '0;
                        state_in = nttfwd_pkg::ST_LD_X;
                     end
                  end
                  default: begin
                     rd_index_in = req_index;
                     rd_ok_in    = idx_ok;
                     state_in    = nttfwd_pkg::ST_READ;
                  end
               endcase
            end
         end
         nttfwd_pkg::ST_READ: begin
            coef_raddr = AW'(rd_index_ff);
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = rd_index_ff;
               rsp_coef_in  = rd_ok_ff ? coef_rdata : '0;
               rsp_err_in   = error_ff;
               state_in     = nttfwd_pkg::ST_IDLE;
            end
         end
         nttfwd_pkg::ST_LD_X: begin
            state_in = nttfwd_pkg::ST_LD_Y;
         end
         nttfwd_pkg::ST_LD_Y: begin
            coef_raddr = AW'(j_cur + t_ff);
            x_in       = coef_rdata;
            w_in       = tw_rdata;
            state_in   = nttfwd_pkg::ST_START;
         end
         nttfwd_pkg::ST_START: begin
            bf_start = 1'b1;
            state_in = nttfwd_pkg::ST_BUSY;
         end
         nttfwd_pkg::ST_BUSY: begin
            coef_waddr = AW'(j_cur);
            coef_wdata = bf_sum;
            if (bf_done) begin
               coef_we  = 1'b1;
               state_in = nttfwd_pkg::ST_WR_Y;
            end
         end
         nttfwd_pkg::ST_WR_Y: begin
            coef_we    = 1'b1;
            coef_waddr = AW'(j_cur + t_ff);
            coef_wdata = bf_diff;
            state_in   = nttfwd_pkg::ST_LD_X;
            if (k_ff + 1'b1 != t_ff) begin
               k_in = k_ff + 1'b1;
            end else begin
               k_in = '0;
               if (i_ff + 1'b1 != m_ff) begin
                  i_in    = i_ff + 1'b1;
                  base_in = base_ff + (t_ff << 1);
               end else begin
                  i_in    = '0;
                  base_in = '0;
                  m_in    = m_ff << 1;
                  t_in    = t_ff >> 1;
                  if ((m_ff << 1) == len_ff) begin
                     state_in = nttfwd_pkg::ST_IDLE;
                  end
               end
            end
         end
         default: state_in = nttfwd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nttfwd_pkg::ST_IDLE;
         error_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         error_ff     <= error_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      len_ff       <= len_in;
      m_ff         <= m_in;
      t_ff         <= t_in;
      i_ff         <= i_in;
      k_ff         <= k_in;
      base_ff      <= base_in;
      x_ff         <= x_in;
      w_ff         <= w_in;
      rd_index_ff  <= rd_index_in;
      rd_ok_ff     <= rd_ok_in;
      rsp_index_ff <= rsp_index_in;
      rsp_coef_ff  <= rsp_coef_in;
      rsp_err_ff   <= rsp_err_in;
   end

   nttfwd_ram #(.WIDTH(WORD_BITS), .DEPTH(MAX_POINTS)) u_coef_ram (
      .clock (clock),
      .we    (coef_we),
      .waddr (coef_waddr),
      .wdata (coef_wdata),
      .raddr (coef_raddr),
      .rdata (coef_rdata)
   );

   nttfwd_ram #(.WIDTH(WORD_BITS), .DEPTH(MAX_POINTS)) u_tw_ram (
      .clock (clock),
      .we    (tw_we),
      .waddr (AW'(req_index)),
      .wdata (req_value),
      .raddr (tw_raddr),
      .rdata (tw_rdata)
   );

   nttfwd_bfly #(.WORD_BITS(WORD_BITS)) u_bfly (
      .clock (clock),
      .reset (reset),
      .start (bf_start),
      .q     (modulus_ff),
      .x     (x_ff),
      .y     (coef_rdata),
      .w     (w_ff),
      .done  (bf_done),
      .sum   (bf_sum),
      .diff  (bf_diff)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'({rsp_coef_ff, rsp_index_ff});
   assign rsp_tuser  = rsp_err_ff;

endmodule

// ===== hdl/nttfwd_check.sv =====
// port-level checker for the forward ntt block, bound to the top level
// depends on nttfwd_pkg and ntt_forward_radix2_bitrev
`timescale 1ns / 1ps

module nttfwd_check #(
   parameter int MAX_POINTS = nttfwd_pkg::MAX_POINTS_DEF,
   parameter int WORD_BITS  = nttfwd_pkg::WORD_BITS_DEF
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic [((nttfwd_pkg::INDEX_BITS+WORD_BITS+7)/8)*8-1:0] req_tdata,
   input logic [nttfwd_pkg::KIND_BITS-1:0] req_tuser,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [((nttfwd_pkg::INDEX_BITS+WORD_BITS+7)/8)*8-1:0] rsp_tdata,
   input logic rsp_tuser,
   input logic csr_we,
   input logic [nttfwd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input logic [WORD_BITS-1:0] csr_wdata
);

   logic       rd_fire, rsp_fire;
   logic [1:0] pend_ff;
   logic       seen_err_ff;

   assign rd_fire  = req_tvalid && req_tready && (req_tuser == nttfwd_pkg::KIND_RD_COEF);
   assign rsp_fire = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff     <= '0;
         seen_err_ff <= 1'b0;
      end else begin
         pend_ff <= pend_ff + 2'(rd_fire) - 2'(rsp_fire);
         if (rsp_fire && rsp_tuser) begin
            seen_err_ff <= 1'b1;
         end
      end
   end

   a_no_invented_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pend_ff != 2'd0) else $error("response without pending read");

   // one response held plus one read waiting for the slot
   a_two_pending: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3) else $error("more than two reads pending");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && seen_err_ff |-> rsp_tuser) else $error("range error flag cleared");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

endmodule

bind ntt_forward_radix2_bitrev nttfwd_check #(
   .MAX_POINTS (MAX_POINTS),
   .WORD_BITS  (WORD_BITS)
) u_nttfwd_check (.*);

// ===== tb/tb_top.sv =====
// self-checking testbench for the forward ntt block: driver, monitor and transform predictor
// depends on nttfwd_pkg and ntt_forward_radix2_bitrev
`timescale 1ns / 1ps

module tb_top;

   localparam int DW = ((nttfwd_pkg::INDEX_BITS + nttfwd_pkg::WORD_BITS_DEF + 7) / 8) * 8;
   localparam int NPTS = nttfwd_pkg::MAX_POINTS_DEF;
   localparam logic [61:0] Q_PRIME = 62'h3FFF_FFFF_FFFF_FFC7;
   localparam logic [61:0] Q_MAX   = 62'h3FFF_FFFF_FFFF_FFFF;
   localparam int STALL_LIMIT = 400000;

   typedef struct packed {
      nttfwd_pkg::kind_type kind;
      logic [11:0]          idx;
      logic [61:0]          val;
   } ntt_op_type;

   typedef struct packed {
      logic [11:0] idx;
      logic [61:0] coef;
      logic        err;
   } readback_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [DW-1:0] req_tdata = '0;
   logic [nttfwd_pkg::KIND_BITS-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [DW-1:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_we = 1'b0;
   logic [nttfwd_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [61:0] csr_wdata = '0;

   ntt_forward_radix2_bitrev dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [61:0] coef_mem [NPTS];
   logic [61:0] tw_mem [NPTS];
   logic        err_flag;
   logic [61:0] mod_q;
   logic [3:0]  size_lg;

   // generator view of which entries hold data
   bit coef_ok [NPTS];
   bit tw_ok [NPTS];
   logic [61:0] gen_q;

   ntt_op_type   op_queue [$];
   readback_type readback_queue [$];
   ntt_op_type   cur_op;
   int  mismatches = 0;
   int  ops_queued = 0;
   bit  drv_busy_free = 0;
   bit  mon_busy_free = 0;
   int  drv_gap = 0;
   int  mon_gap = 0;
   int  idle_cycles = 0;

   function automatic int draw_gap(bit no_idle);
      if (no_idle)
         return 0;
      return $urandom_range(0, 13);
   endfunction

   function automatic void transform_stores();
      logic [63:0] q;
      int lg, len, t, m, i, j, base;
      logic [63:0] w, x, y, wy;
      logic [127:0] prod;
      q = {2'b00, mod_q};
      lg = size_lg;
      if (q < 2)
         return;
      if (lg < 1)
         lg = 1;
      if (lg > 12)
         lg = 12;
      len = 1 << lg;
      t = len >> 1;
      for (m = 1; m < len; m = m << 1) begin
         base = 0;
         for (i = 0; i < m; i++) begin
            w = {2'b00, tw_mem[m + i]} % q;
            for (j = base; j < base + t; j++) begin
               x = {2'b00, coef_mem[j]} % q;
               y = {2'b00, coef_mem[j + t]} % q;
               prod = y * w;
               wy = 64'(prod % {64'd0, q});
               coef_mem[j]     = 62'((x + wy) % q);
               coef_mem[j + t] = 62'((x >= wy) ? x - wy : x + q - wy);
            end
            base += t << 1;
         end
         t = t >> 1;
      end
   endfunction

   function automatic void apply_op(ntt_op_type op);
      readback_type rb;
      case (op.kind)
         nttfwd_pkg::KIND_WR_TWIDDLE, nttfwd_pkg::KIND_WR_COEF: begin
            if (op.val >= mod_q)
               err_flag = 1'b1;
            else if (op.kind == nttfwd_pkg::KIND_WR_TWIDDLE)
               tw_mem[op.idx] = op.val;
            else
               coef_mem[op.idx] = op.val;
         end
         nttfwd_pkg::KIND_RUN: transform_stores();
         default: begin
            rb.idx = op.idx;
            rb.coef = coef_mem[op.idx];
            rb.err = err_flag;
            readback_queue.push_back(rb);
         end
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      bit fire;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         fire = req_tvalid && req_tready;
         if (fire) begin
            apply_op(cur_op);
            drv_gap = draw_gap(drv_busy_free);
         end
         if (!req_tvalid || fire) begin
            if (drv_gap == 0 && op_queue.size() > 0) begin
               cur_op = op_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= DW'({cur_op.val, cur_op.idx});
               req_tuser <= cur_op.kind;
            end else begin
               req_tvalid <= 1'b0;
               if (drv_gap > 0)
                  drv_gap--;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      readback_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (readback_queue.size() == 0) begin
               $error("unexpected response transaction idx=%0d", rsp_tdata[11:0]);
               mismatches++;
            end else begin
               want = readback_queue.pop_front();
               if (rsp_tdata[11:0] !== want.idx) begin
                  $error("index_out: expected %0d, actual %0d", want.idx, rsp_tdata[11:0]);
                  mismatches++;
               end
               if (rsp_tdata[73:12] !== want.coef) begin
                  $error("coefficient: expected %0d, actual %0d", want.coef,
                         rsp_tdata[73:12]);
                  mismatches++;
               end
               if (rsp_tuser !== want.err) begin
                  $error("range_error: expected %0d, actual %0d", want.err, rsp_tuser);
                  mismatches++;
               end
            end
            mon_gap = draw_gap(mon_busy_free);
         end
         if (mon_gap > 0) begin
            mon_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic logic [61:0] rand62();
      return 62'({$urandom, $urandom});
   endfunction

   function automatic logic [61:0] in_range();
      return (gen_q == 0) ? 62'd0 : rand62() % gen_q;
   endfunction

   task automatic push_op(nttfwd_pkg::kind_type k, int idx, logic [61:0] v);
      ntt_op_type op;
      op.kind = k;
      op.idx = 12'(idx);
      op.val = v;
      if ((k == nttfwd_pkg::KIND_WR_COEF || k == nttfwd_pkg::KIND_WR_TWIDDLE) && v < gen_q) begin
         if (k == nttfwd_pkg::KIND_WR_COEF)
            coef_ok[idx] = 1;
         else
            tw_ok[idx] = 1;
      end
      op_queue.push_back(op);
      ops_queued++;
   endtask

   task automatic push_read_any();
      int idx;
      do
         idx = $urandom_range(0, NPTS - 1);
      while (!coef_ok[idx] && $urandom_range(0, 3) != 0);
      if (!coef_ok[idx])
         idx = 0;
      push_op(nttfwd_pkg::KIND_RD_COEF, idx, rand62());
   endtask

   task automatic wait_idle();
      wait (op_queue.size() == 0 && readback_queue.size() == 0 && !req_tvalid);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic [nttfwd_pkg::CSR_INDEX_BITS-1:0] which, logic [61:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= which;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      if (which == nttfwd_pkg::CSR_MODULUS)
         mod_q = v;
      else
         size_lg = v[3:0];
   endtask

   task automatic set_phase(logic [61:0] q, logic [3:0] lg);
      wait_idle();
      csr_write(nttfwd_pkg::CSR_MODULUS, q);
      csr_write(nttfwd_pkg::CSR_SIZE_LOG2, {58'd0, lg});
      gen_q = q;
      drv_busy_free = ($urandom_range(0, 3) == 0);
      mon_busy_free = ($urandom_range(0, 3) == 0);
   endtask

   // one load / transform / read-back sequence, or plain traffic for long lengths, a modulus below 2, or at random
   task automatic random_sequence(int eff_lg);
      int len, n, i, idx;
      bit all_tw;
      len = 1 << eff_lg;
      if (eff_lg <= 5 && gen_q >= 2 && $urandom_range(0, 9) != 0) begin
         for (i = 0; i < len; i++)
            if (!coef_ok[i] || $urandom_range(0, 4) != 0)
               push_op(nttfwd_pkg::KIND_WR_COEF, i, in_range());
         all_tw = 1;
         for (i = 1; i < len; i++)
            all_tw &= tw_ok[i];
         if (!all_tw || $urandom_range(0, 1))
            for (i = 1; i < len; i++)
               push_op(nttfwd_pkg::KIND_WR_TWIDDLE, i, in_range());
         if ($urandom_range(0, 29) == 0)
            push_op(nttfwd_pkg::kind_type'($urandom_range(0, 1)), $urandom_range(0, NPTS - 1),
                    gen_q + 62'($urandom_range(0, 7)) |
                    (rand62() & {62{1'($urandom_range(0, 1))}}));
         push_op(nttfwd_pkg::KIND_RUN, 0, rand62());
         n = $urandom_range(1, len);
         for (i = 0; i < n; i++)
            push_op(nttfwd_pkg::KIND_RD_COEF, $urandom_range(0, len - 1), rand62());
      end else begin
         n = $urandom_range(4, 20);
         for (i = 0; i < n; i++) begin
            idx = $urandom_range(0, NPTS - 1);
            case ($urandom_range(0, 5))
               0: push_op(nttfwd_pkg::KIND_WR_TWIDDLE, idx, in_range());
               1, 2: push_op(nttfwd_pkg::KIND_WR_COEF, idx, in_range());
               3: push_op(nttfwd_pkg::kind_type'($urandom_range(0, 1)), idx, rand62());
               default: push_read_any();
            endcase
         end
      end
      push_read_any();
   endtask

   initial begin
      logic [61:0] q;
      logic [3:0] lg;
      int eff, s, nseq;
      err_flag = 1'b0;
      mod_q = 62'd2;
      size_lg = nttfwd_pkg::SIZE_LOG2_RESET;
      gen_q = 62'd2;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, then extremes of a large prime and of the largest modulus
      push_op(nttfwd_pkg::KIND_WR_COEF, 5, 62'd1);
      push_op(nttfwd_pkg::KIND_RD_COEF, 5, 62'd0);
      set_phase(Q_PRIME, 4'd1);
      push_op(nttfwd_pkg::KIND_WR_TWIDDLE, 1, Q_PRIME - 1);
      push_op(nttfwd_pkg::KIND_WR_COEF, 0, Q_PRIME - 1);
      push_op(nttfwd_pkg::KIND_WR_COEF, 1, Q_PRIME - 1);
      push_op(nttfwd_pkg::KIND_RUN, 0, 62'd0);
      push_op(nttfwd_pkg::KIND_RD_COEF, 0, 62'd0);
      push_op(nttfwd_pkg::KIND_RD_COEF, 1, 62'd0);
      push_op(nttfwd_pkg::KIND_WR_COEF, NPTS - 1, 62'd0);
      push_op(nttfwd_pkg::KIND_WR_TWIDDLE, NPTS - 1, Q_PRIME - 1);
      push_op(nttfwd_pkg::KIND_RD_COEF, NPTS - 1, Q_MAX);
      set_phase(Q_MAX, 4'd0);
      push_op(nttfwd_pkg::KIND_WR_COEF, 2, Q_MAX - 1);
      push_op(nttfwd_pkg::KIND_RUN, 0, 62'd0);
      push_op(nttfwd_pkg::KIND_RD_COEF, 0, 62'd0);
      push_op(nttfwd_pkg::KIND_RD_COEF, 2, 62'd0);
      // stale words reduced by a small modulus, then out-of-range writes
      set_phase(62'd17, 4'd1);
      push_op(nttfwd_pkg::KIND_RUN, 0, 62'd0);
      push_op(nttfwd_pkg::KIND_RD_COEF, 1, 62'd0);
      push_op(nttfwd_pkg::KIND_WR_COEF, 3, Q_MAX);
      push_op(nttfwd_pkg::KIND_WR_TWIDDLE, 3, 62'd17);
      push_op(nttfwd_pkg::KIND_RD_COEF, 0, 62'd0);
      // degenerate modulus: run leaves the store alone
      set_phase(62'd0, 4'd15);
      push_op(nttfwd_pkg::KIND_RUN, 0, 62'd0);
      push_op(nttfwd_pkg::KIND_RD_COEF, 1, 62'd0);

      while (ops_queued < 1900) begin
         case ($urandom_range(0, 9))
            0: q = Q_MAX;
            1: q = Q_PRIME;
            2: q = 62'd2 + 62'($urandom_range(0, 30));
            3: q = 62'd3;
            default: q = rand62() | 62'd2;
         endcase
         case ($urandom_range(0, 11))
            0: lg = 4'd0;
            1: lg = 4'd5;
            2: lg = 4'd12;
            3: lg = 4'($urandom_range(13, 15));
            default: lg = 4'($urandom_range(1, 4));
         endcase
         set_phase(q, lg);
         eff = (lg < 1) ? 1 : (lg > 12) ? 12 : lg;
         nseq = $urandom_range(2, 6);
         for (s = 0; s < nseq && ops_queued < 1900; s++)
            random_sequence(eff);
      end

      wait_idle();
      repeat (50) @(posedge clock);
      if (mismatches == 0 && readback_queue.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
